>>> design/rala_pkg.sv
// Package: payload types, carry types, status codes and states for the route/ARP lookup unit.
`timescale 1ns / 1ps
package rala_pkg;

  localparam int ROUTE_ENTRIES_DEF = 64;
  localparam int ARP_ENTRIES_DEF   = 64;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_LEARN  = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [2:0] ST_FORWARD  = 3'd0;
  localparam logic [2:0] ST_AWAIT    = 3'd1;
  localparam logic [2:0] ST_NOROUTE  = 3'd2;
  localparam logic [2:0] ST_LEARNED  = 3'd3;
  localparam logic [2:0] ST_KNOWN    = 3'd4;
  localparam logic [2:0] ST_ARP_FULL = 3'd5;
  localparam logic [2:0] ST_LOADED   = 3'd6;

  localparam logic REG_ROUTE_COUNT = 1'b0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [3:0]  port;
    logic [47:0] mac;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] next_hop_ip;
    logic [47:0] next_hop_mac;
    logic [3:0]  out_port;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic        lookup;
    logic [31:0] addr;
    logic        found;
    logic [31:0] best;
    logic [31:0] gateway;
    logic [3:0]  port;
  } route_carry_t;

  typedef struct packed {
    logic        valid;
    logic        lookup;
    logic        route_found;
    logic [31:0] hop;
    logic [3:0]  port;
    logic        found;
    logic [47:0] mac;
  } arp_carry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_HOLD
  } state_t;

endpackage

>>> design/rala_route_cell.sv
// One route table entry: holds prefix/mask/gateway/port and folds its match into the carry.
`timescale 1ns / 1ps
module rala_route_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  rala_pkg::in_item_t    wr_data,
  input  logic                  en,
  input  rala_pkg::route_carry_t carry_in,
  output rala_pkg::route_carry_t carry_out
);
  import rala_pkg::*;

  logic [31:0] prefix;
  logic [31:0] mask;
  logic [31:0] gateway;
  logic [3:0]  port;
  logic [31:0] sub;
  logic        take;
  route_carry_t carry_next;

  always_ff @(posedge clk) begin
    if (wr) begin
      prefix  <= wr_data.addr;
      mask    <= wr_data.mask;
      gateway <= wr_data.gateway;
      port    <= wr_data.port;
    end
  end

  always_comb begin
    sub  = carry_in.addr & mask;
    take = en && carry_in.lookup && (sub == prefix) &&
           (!carry_in.found || sub >= carry_in.best);
    carry_next = carry_in;
    if (take) begin
      carry_next.found   = 1'b1;
      carry_next.best    = sub;
      carry_next.gateway = gateway;
      carry_next.port    = port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out.valid <= 1'b0;
    end else begin
      carry_out.valid <= carry_next.valid;
    end
    carry_out.lookup  <= carry_next.lookup;
    carry_out.addr    <= carry_next.addr;
    carry_out.found   <= carry_next.found;
    carry_out.best    <= carry_next.best;
    carry_out.gateway <= carry_next.gateway;
    carry_out.port    <= carry_next.port;
  end
endmodule

>>> design/rala_arp_cell.sv
// One ARP cache entry: holds IP/MAC and records the first hit along the chain.
`timescale 1ns / 1ps
module rala_arp_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  logic [31:0]         wr_ip,
  input  logic [47:0]         wr_mac,
  input  logic                en,
  input  rala_pkg::arp_carry_t carry_in,
  output rala_pkg::arp_carry_t carry_out
);
  import rala_pkg::*;

  logic [31:0] ip;
  logic [47:0] mac;
  arp_carry_t  carry_next;

  always_ff @(posedge clk) begin
    if (wr) begin
      ip  <= wr_ip;
      mac <= wr_mac;
    end
  end

  always_comb begin
    carry_next = carry_in;
    if (en && !carry_in.found && carry_in.hop == ip) begin
      carry_next.found = 1'b1;
      carry_next.mac   = mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out.valid <= 1'b0;
    end else begin
      carry_out.valid <= carry_next.valid;
    end
    carry_out.lookup      <= carry_next.lookup;
    carry_out.route_found <= carry_next.route_found;
    carry_out.hop         <= carry_next.hop;
    carry_out.port        <= carry_next.port;
    carry_out.found       <= carry_next.found;
    carry_out.mac         <= carry_next.mac;
  end
endmodule

>>> design/route_and_arp_lookup_unit.sv
// Top level: route cell chain feeding ARP cell chain, sequencer, output register, APB port.
//
//   channel  | signals                          | transaction
//   in       | in_valid, in_stall, in_data      | one load, learn or lookup item
//   out      | out_valid, out_stall, out_data   | one result item
//   cfg      | APB psel/penable/pwrite/paddr    | route_count register
//
// A load goes straight to the output register; learn and lookup items walk through the route
// chain and then the ARP chain, one cell per cycle, before their result is registered.
// One item is in flight at a time; in_stall is high until its result is taken.
// Reset clears route_count, the ARP fill count and the chain valid bits.
// A stalled result holds in the output register.
module route_and_arp_lookup_unit #(
  parameter int ROUTE_ENTRIES = rala_pkg::ROUTE_ENTRIES_DEF,
  parameter int ARP_ENTRIES   = rala_pkg::ARP_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rala_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rala_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rala_pkg::*;

  localparam int AW = $clog2(ARP_ENTRIES + 1);

  state_t       state, state_next;
  logic [6:0]   route_count;
  logic [AW-1:0] arp_count;
  out_item_t    result, result_next;
  logic         in_acc;
  logic         inject;
  logic         append;
  logic         load_ok;

  route_carry_t rc [ROUTE_ENTRIES+1];
  arp_carry_t   ac [ARP_ENTRIES+1];
  arp_carry_t   tail;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ROUTE_COUNT) ? {25'd0, route_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= 7'd0;
    end else if (psel && penable && pwrite && paddr[2] == REG_ROUTE_COUNT) begin
      route_count <= pwdata[6:0];
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign inject    = in_acc && (in_data.kind == KIND_LEARN || in_data.kind == KIND_LOOKUP);
  assign load_ok   = in_acc && in_data.kind == KIND_LOAD && 32'(in_data.slot) < ROUTE_ENTRIES;
  assign out_valid = (state == S_HOLD);
  assign out_data  = result;

  always_comb begin
    rc[0].valid   = inject;
    rc[0].lookup  = (in_data.kind == KIND_LOOKUP);
    rc[0].addr    = in_data.addr;
    rc[0].found   = 1'b0;
    rc[0].best    = 32'd0;
    rc[0].gateway = 32'd0;
    rc[0].port    = 4'd0;
  end

  genvar i;
  generate
    for (i = 0; i < ROUTE_ENTRIES; i++) begin : g_route
      rala_route_cell u_cell (
        .clk(clk), .rst(rst),
        .wr(load_ok && 32'(in_data.slot) == i),
        .wr_data(in_data),
        .en(32'(route_count) > i),
        .carry_in(rc[i]),
        .carry_out(rc[i+1])
      );
    end
  endgenerate

  always_comb begin
    ac[0].valid       = rc[ROUTE_ENTRIES].valid;
    ac[0].lookup      = rc[ROUTE_ENTRIES].lookup;
    ac[0].route_found = rc[ROUTE_ENTRIES].found;
    ac[0].hop         = (rc[ROUTE_ENTRIES].lookup && rc[ROUTE_ENTRIES].gateway != 32'd0) ?
                        rc[ROUTE_ENTRIES].gateway : rc[ROUTE_ENTRIES].addr;
    ac[0].port        = rc[ROUTE_ENTRIES].port;
    ac[0].found       = 1'b0;
    ac[0].mac         = 48'd0;
  end

  logic [47:0] learn_mac;
  always_ff @(posedge clk) begin
    if (inject) begin
      learn_mac <= in_data.mac;
    end
  end

  generate
    for (i = 0; i < ARP_ENTRIES; i++) begin : g_arp
      rala_arp_cell u_cell (
        .clk(clk), .rst(rst),
        .wr(append && arp_count == AW'(i)),
        .wr_ip(tail.hop),
        .wr_mac(learn_mac),
        .en(AW'(i) < arp_count),
        .carry_in(ac[i]),
        .carry_out(ac[i+1])
      );
    end
  endgenerate

  assign tail   = ac[ARP_ENTRIES];
  assign append = tail.valid && !tail.lookup && !tail.found &&
                  32'(arp_count) < ARP_ENTRIES;

  always_ff @(posedge clk) begin
    if (rst) begin
      arp_count <= '0;
    end else if (append) begin
      arp_count <= arp_count + AW'(1);
    end
  end

  always_comb begin
    result_next = '0;
    if (!tail.lookup) begin
      if (tail.found) begin
        result_next.status = ST_KNOWN;
      end else if (32'(arp_count) >= ARP_ENTRIES) begin
        result_next.status = ST_ARP_FULL;
      end else begin
        result_next.status = ST_LEARNED;
      end
    end else if (!tail.route_found) begin
      result_next.status = ST_NOROUTE;
    end else begin
      result_next.status       = tail.found ? ST_FORWARD : ST_AWAIT;
      result_next.next_hop_ip  = tail.hop;
      result_next.next_hop_mac = tail.found ? tail.mac : 48'd0;
      result_next.out_port     = tail.port;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.kind == KIND_LOAD) begin
      result <= '{status: ST_LOADED, next_hop_ip: 32'd0, next_hop_mac: 48'd0,
                  out_port: 4'd0};
    end else if (tail.valid) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (inject) state_next = S_BUSY;
        else if (in_acc && in_data.kind == KIND_LOAD) state_next = S_HOLD;
      end
      S_BUSY: begin
        if (tail.valid) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_inject_busy: assert property (@(posedge clk) disable iff (rst)
    inject |=> state == S_BUSY)
    else $error("lookup or learn did not enter the chain");
  a_tail_only_busy: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> state == S_BUSY)
    else $error("chain result outside busy state");
  a_arp_bound: assert property (@(posedge clk) disable iff (rst)
    32'(arp_count) <= ARP_ENTRIES)
    else $error("ARP fill count overflow");
  a_append_learn: assert property (@(posedge clk) disable iff (rst)
    append |=> result.status == ST_LEARNED)
    else $error("append without learned status");
`endif
endmodule

>>> dv/testbench.sv
// Testbench for the route and ARP lookup unit: random and directed items checked against a predictor.
`timescale 1ns / 1ps
module testbench;
  import rala_pkg::*;

  class route_arp_scoreboard;
    logic [31:0] rt_prefix[64];
    logic [31:0] rt_mask[64];
    logic [31:0] rt_gw[64];
    logic [3:0]  rt_port[64];
    logic [31:0] arp_ip[64];
    logic [47:0] arp_mac[64];
    int          arp_fill;
    int          route_count;
    out_item_t   pending_results[$];
    int          mismatches;

    function void note_item(in_item_t it);
      out_item_t r;
      int i;
      int pick;
      bit hit;
      logic [31:0] best;
      logic [31:0] sub;
      logic [31:0] hop;
      r = '0;
      hit = 0;
      pick = 0;
      best = '0;
      if (it.kind == KIND_LOAD) begin
        rt_prefix[it.slot] = it.addr;
        rt_mask[it.slot] = it.mask;
        rt_gw[it.slot] = it.gateway;
        rt_port[it.slot] = it.port;
        r.status = ST_LOADED;
      end else if (it.kind == KIND_LEARN) begin
        r.status = ST_LEARNED;
        for (i = 0; i < arp_fill; i++) if (arp_ip[i] == it.addr) hit = 1;
        if (hit) r.status = ST_KNOWN;
        else if (arp_fill >= 64) r.status = ST_ARP_FULL;
        else begin
          arp_ip[arp_fill] = it.addr;
          arp_mac[arp_fill] = it.mac;
          arp_fill++;
        end
      end else if (it.kind == KIND_LOOKUP) begin
        for (i = 0; i < (route_count > 64 ? 64 : route_count); i++) begin
          sub = it.addr & rt_mask[i];
          if (sub == rt_prefix[i] && (!hit || sub >= best)) begin
            hit = 1;
            best = sub;
            pick = i;
          end
        end
        if (!hit) r.status = ST_NOROUTE;
        else begin
          hop = (rt_gw[pick] == 0) ? it.addr : rt_gw[pick];
          r.status = ST_AWAIT;
          r.next_hop_ip = hop;
          r.out_port = rt_port[pick];
          for (i = arp_fill - 1; i >= 0; i--) if (arp_ip[i] == hop) begin
            r.status = ST_FORWARD;
            r.next_hop_mac = arp_mac[i];
          end
        end
      end else return;
      pending_results.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.next_hop_ip !== want.next_hop_ip ||
          got.next_hop_mac !== want.next_hop_mac || got.out_port !== want.out_port) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_data;
  out_item_t out_data;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  route_arp_scoreboard sb;
  bit loaded[64];
  int hold_off;
  logic [31:0] pool_ip[16];

  route_and_arp_lookup_unit u_dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) if (!rst && out_valid && !out_stall) sb.check_result(out_data);

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_stall = 0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off > 0) begin
        out_stall <= 1;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end else if ($urandom_range(3) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(9) == 0 ? $urandom_range(40, 200) : $urandom_range(1, 3))
          @(posedge clk);
      end else begin
        out_stall <= 0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_item(in_item_t it);
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    if ($urandom_range(3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(15) == 0 ? $urandom_range(20, 150) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  task automatic write_route_count(logic [31:0] v);
    in_valid <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'd0; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.route_count = v & 32'h7f;
  endtask

  function automatic in_item_t rand_item(int kind);
    in_item_t it;
    it.kind = 2'(kind);
    it.slot = 6'($urandom);
    it.addr = $urandom;
    it.mask = $urandom;
    it.gateway = $urandom;
    it.port = 4'($urandom);
    it.mac = 48'({$urandom, $urandom});
    return it;
  endfunction

  // well-formed route whose prefix fits its mask, addresses drawn from a small pool
  function automatic in_item_t route_item(int s);
    in_item_t it;
    int len;
    it = rand_item(KIND_LOAD);
    it.slot = 6'(s);
    len = $urandom_range(0, 32);
    it.mask = (len == 0) ? 32'h0 : ~32'h0 << (32 - len);
    if ($urandom_range(7) == 0) it.mask = $urandom;
    it.addr = pool_ip[$urandom_range(15)] & it.mask;
    it.gateway = $urandom_range(2) == 0 ? 32'h0 : pool_ip[$urandom_range(15)];
    return it;
  endfunction

  task automatic load_slot(in_item_t it);
    send_item(it);
    loaded[it.slot] = 1;
  endtask

  task automatic lookup(logic [31:0] a);
    in_item_t it;
    it = rand_item(KIND_LOOKUP);
    it.addr = a;
    send_item(it);
  endtask

  initial begin
    in_item_t it;
    int cnt;
    int phase;
    sb = new();
    rst = 1; in_valid = 0; in_data = '0; psel = 0; penable = 0; pwrite = 0;
    paddr = '0; pwdata = '0; hold_off = 0;
    for (int i = 0; i < 16; i++) pool_ip[i] = $urandom;
    pool_ip[0] = 32'h0; pool_ip[1] = 32'hffffffff;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: lookups with no routes, field extremes, unused kind
    lookup(32'h0);
    lookup(32'hffffffff);
    it = rand_item(3);
    send_item(it);
    it = rand_item(KIND_LOAD);
    it.slot = 0; it.addr = 0; it.mask = 0; it.gateway = 0; it.port = 0;
    load_slot(it);
    it.slot = 63; it.addr = 32'hffffffff; it.mask = 32'hffffffff;
    it.gateway = 32'hffffffff; it.port = 4'hf;
    load_slot(it);
    it = rand_item(KIND_LEARN); it.addr = 32'hffffffff; it.mac = '1;
    send_item(it);
    send_item(it);
    it.addr = 0; it.mac = '0;
    send_item(it);
    write_route_count(1);
    lookup(32'h12345678);
    write_route_count(0);
    lookup(32'h12345678);
    for (int s = 1; s < 63; s++) load_slot(route_item(s));
    write_route_count(64);
    lookup(32'hffffffff);
    lookup(32'h0);
    write_route_count(127);
    lookup(32'hffffffff);

    // long receiver hold-off while items keep coming
    hold_off = 400;
    for (int k = 0; k < 6; k++) lookup(pool_ip[$urandom_range(15)]);

    // random phases
    for (phase = 0; phase < 6; phase++) begin
      for (int k = 0; k < 100; k++) begin
        case ($urandom_range(9))
          0, 1: load_slot(route_item($urandom_range(63)));
          2, 3: begin
            it = rand_item(KIND_LEARN);
            if ($urandom_range(1)) it.addr = pool_ip[$urandom_range(15)];
            send_item(it);
          end
          4: begin
            it = rand_item($urandom_range(3));
            if (it.kind == KIND_LOAD) loaded[it.slot] = 1;
            send_item(it);
          end
          default: lookup($urandom_range(1) ? pool_ip[$urandom_range(15)] ^ $urandom_range(255)
                                            : $urandom);
        endcase
      end
      cnt = 0;
      while (cnt < 64 && loaded[cnt]) cnt++;
      if (phase == 5) cnt = 0;
      write_route_count(phase[0] ? cnt : $urandom_range(0, cnt));
    end

    in_valid <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> files.f
design/rala_pkg.sv
design/rala_route_cell.sv
design/rala_arp_cell.sv
design/route_and_arp_lookup_unit.sv
dv/testbench.sv
